### sv/e2cx_pkg.sv
// ----------------------------------------------------------------------------
// e2cx_pkg
// Shared types and fixed-point constants for the equirectangular to cube
// cross sampler.
// ----------------------------------------------------------------------------
package e2cx_pkg;

    // Width of cube coordinates and CORDIC vector registers, signed.
    localparam int CW = 22;
    // Width of angle registers, signed Q4.16.
    localparam int AW = 21;
    // Width of clamped angle sums, unsigned.
    localparam int TW = 19;

    localparam int FX_PI         = 205887;
    localparam int FX_HALF_PI    = 102944;
    localparam int FX_ONE        = 65536;
    localparam int FX_INV_PI_Q24 = 5340354;
    localparam int FX_INV_GAIN   = 39797;
    localparam int DIV_BITS      = 17;
    localparam int ATAN_ENTRIES  = 24;

    localparam int ATAN_TAB [ATAN_ENTRIES] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum logic {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } reg_idx_t;

    // Data that travels beside the arithmetic through the pipeline.
    typedef struct packed {
        logic [12:0]          dst_x;
        logic [12:0]          dst_y;
        logic [2:0]           face;
        logic signed [CW-1:0] pz;
        logic signed [AW-1:0] theta;
    } side_t;

endpackage

### sv/equirect_to_cube_cross_sampler_core.sv
// ----------------------------------------------------------------------------
// equirect_to_cube_cross_sampler_core
// Maps each destination pixel of a vertical cross cube map to the two
// neighboring source columns and rows of an equirectangular panorama, with
// bilinear weights.
// ----------------------------------------------------------------------------
// Usage: a word on the s_ channel carries a cube face number, a column and a
// row on that face. For each word the m_ channel returns one word with the
// destination position in the cross, the clamped source columns and rows
// around the sampled point and the fractional weights in Q1.FRAC_BITS.
// The user must write the source width and height through the APB-style
// port while no word is in flight; the block does not enforce it. Reads
// return the stored values. The pipeline takes one word every cycle unless
// the output stalls. Its depth is set by the restoring divider (one quotient
// bit per stage) and the two CORDIC units (one iteration per stage) that
// run one after the other.
// Reset clears all valid bits and loads width 1024 and height 512.
// When the receiver holds m_tready low with a word waiting, the whole
// pipeline holds and s_tready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module equirect_to_cube_cross_sampler_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int MAX_WIDTH    = 8192,
    parameter int FRAC_BITS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // face [2:0], col [13:3], row [24:14]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // dst_x, dst_y, u_lo, u_hi, v_lo, v_hi (13 bits each), frac_u, frac_v
    output logic [((78 + 2 * (FRAC_BITS + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import e2cx_pkg::*;

    localparam int N     = CORDIC_STEPS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int OW    = ((78 + 2 * FW + 7) / 8) * 8;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int FSW   = $clog2(MAX_WIDTH / 4 + 1);
    localparam int PW    = FSW + 1 + TW;
    localparam int UW    = PW - 1;
    localparam int LAT   = 2 * N + 27;

    // Configuration registers.
    logic [13:0] src_width_reg, src_height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= 14'd1024;
            src_height_reg <= 14'd512;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[13:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_SRC_WIDTH:  prdata = {18'd0, src_width_reg};
            REG_SRC_HEIGHT: prdata = {18'd0, src_height_reg};
            default:        prdata = 32'd0;
        endcase
    end

    logic [WW-1:0]  w_lim, h_lim, w_m1, h_m1;
    logic [FSW-1:0] fs;

    assign w_lim = (src_width_reg > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(src_width_reg);
    assign h_lim = (src_height_reg > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(src_height_reg);
    assign w_m1  = (w_lim != '0) ? w_lim - 1'b1 : '0;
    assign h_m1  = (h_lim != '0) ? h_lim - 1'b1 : '0;
    assign fs    = FSW'(w_lim >> 2);

    // Pipeline control.
    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Input stage: unpack and form the cross offsets.
    logic [10:0] col_reg, row_reg;
    side_t       s0_reg;
    logic [12:0] offx, offy;
    logic [2:0]  in_face;

    assign in_face = s_tdata[2:0];

    always_comb begin
        case (in_face)
            3'd0:    begin offx = 13'(fs);      offy = 13'(3 * fs); end
            3'd1:    begin offx = 13'd0;        offy = 13'(fs);     end
            3'd2:    begin offx = 13'(fs);      offy = 13'(fs);     end
            3'd3:    begin offx = 13'(2 * fs);  offy = 13'(fs);     end
            3'd4:    begin offx = 13'(fs);      offy = 13'd0;       end
            3'd5:    begin offx = 13'(fs);      offy = 13'(2 * fs); end
            default: begin offx = 13'd0;        offy = 13'd0;       end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            col_reg      <= s_tdata[13:3];
            row_reg      <= s_tdata[24:14];
            s0_reg.dst_x <= 13'(s_tdata[13:3]) + offx;
            s0_reg.dst_y <= 13'(s_tdata[24:14]) + offy;
            s0_reg.face  <= in_face;
            s0_reg.pz    <= '0;
            s0_reg.theta <= '0;
        end
    end

    // Restoring dividers for col*2^17/fs and row*2^17/fs, one bit a stage.
    logic [FSW-1:0]      rema_reg [0:DIV_BITS];
    logic [FSW-1:0]      remb_reg [0:DIV_BITS];
    logic [DIV_BITS-1:0] qa_reg   [0:DIV_BITS];
    logic [DIV_BITS-1:0] qb_reg   [0:DIV_BITS];
    logic                sata_reg [0:DIV_BITS];
    logic                satb_reg [0:DIV_BITS];
    logic                fsz_reg  [0:DIV_BITS];
    side_t               sd_reg   [0:DIV_BITS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            fsz_reg[0]  <= (fs == '0);
            sata_reg[0] <= (fs != '0) && (32'(col_reg) >= 32'(fs));
            satb_reg[0] <= (fs != '0) && (32'(row_reg) >= 32'(fs));
            rema_reg[0] <= FSW'(col_reg);
            remb_reg[0] <= FSW'(row_reg);
            qa_reg[0]   <= '0;
            qb_reg[0]   <= '0;
            sd_reg[0]   <= s0_reg;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        logic [FSW:0] ra2, rb2;
        logic         gea, geb;

        assign ra2 = {rema_reg[k], 1'b0};
        assign rb2 = {remb_reg[k], 1'b0};
        assign gea = ra2 >= {1'b0, fs};
        assign geb = rb2 >= {1'b0, fs};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rema_reg[k+1] <= gea ? FSW'(ra2 - {1'b0, fs}) : FSW'(ra2);
                remb_reg[k+1] <= geb ? FSW'(rb2 - {1'b0, fs}) : FSW'(rb2);
                qa_reg[k+1]   <= {qa_reg[k][DIV_BITS-2:0], gea};
                qb_reg[k+1]   <= {qb_reg[k][DIV_BITS-2:0], geb};
                sata_reg[k+1] <= sata_reg[k];
                satb_reg[k+1] <= satb_reg[k];
                fsz_reg[k+1]  <= fsz_reg[k];
                sd_reg[k+1]   <= sd_reg[k];
            end
        end
    end

    // Cube point.
    logic signed [CW-1:0] a_s, b_s, one_s;
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] px_reg, py_reg;
    side_t                sc_reg;
    side_t                sc_next;

    assign one_s = CW'(FX_ONE);
    assign a_s = fsz_reg[DIV_BITS] ? '0 :
                 sata_reg[DIV_BITS] ? CW'(2 * FX_ONE) : CW'(qa_reg[DIV_BITS]);
    assign b_s = fsz_reg[DIV_BITS] ? '0 :
                 satb_reg[DIV_BITS] ? CW'(2 * FX_ONE) : CW'(qb_reg[DIV_BITS]);

    always_comb begin
        case (sd_reg[DIV_BITS].face)
            3'd0:    begin px = -one_s;      py = a_s - one_s; pz = b_s - one_s; end
            3'd1:    begin px = a_s - one_s; py = -one_s;      pz = one_s - b_s; end
            3'd2:    begin px = one_s;       py = a_s - one_s; pz = one_s - b_s; end
            3'd3:    begin px = one_s - a_s; py = one_s;       pz = one_s - b_s; end
            3'd4:    begin px = b_s - one_s; py = a_s - one_s; pz = one_s;       end
            3'd5:    begin px = one_s - b_s; py = a_s - one_s; pz = -one_s;      end
            default: begin px = '0;          py = '0;          pz = '0;          end
        endcase
    end

    always_comb begin
        sc_next    = sd_reg[DIV_BITS];
        sc_next.pz = pz;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= px;
            py_reg <= py;
            sc_reg <= sc_next;
        end
    end

    // First CORDIC: azimuth and planar magnitude.
    logic signed [CW-1:0] c1x_reg [0:N];
    logic signed [CW-1:0] c1y_reg [0:N];
    logic signed [AW-1:0] c1a_reg [0:N];
    logic                 c1z_reg [0:N];
    side_t                c1s_reg [0:N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1z_reg[0] <= (px_reg == '0) && (py_reg == '0);
            c1s_reg[0] <= sc_reg;
            if (px_reg < 0) begin
                c1x_reg[0] <= -px_reg;
                c1y_reg[0] <= -py_reg;
                c1a_reg[0] <= (py_reg >= 0) ? AW'(FX_PI) : -AW'(FX_PI);
            end else begin
                c1x_reg[0] <= px_reg;
                c1y_reg[0] <= py_reg;
                c1a_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_c1
        always_ff @(posedge aclk) begin
            if (adv) begin
                c1z_reg[k+1] <= c1z_reg[k];
                c1s_reg[k+1] <= c1s_reg[k];
                if (c1y_reg[k] >= 0) begin
                    c1x_reg[k+1] <= c1x_reg[k] + (c1y_reg[k] >>> k);
                    c1y_reg[k+1] <= c1y_reg[k] - (c1x_reg[k] >>> k);
                    c1a_reg[k+1] <= c1a_reg[k] + AW'(ATAN_TAB[k]);
                end else begin
                    c1x_reg[k+1] <= c1x_reg[k] - (c1y_reg[k] >>> k);
                    c1y_reg[k+1] <= c1y_reg[k] + (c1x_reg[k] >>> k);
                    c1a_reg[k+1] <= c1a_reg[k] - AW'(ATAN_TAB[k]);
                end
            end
        end
    end

    // Gain correction of the magnitude.
    logic [37:0]          r_prod;
    logic signed [CW-1:0] r_reg;
    side_t                sm_reg;
    side_t                sm_next;

    assign r_prod = 38'(unsigned'(c1x_reg[N])) * 38'(FX_INV_GAIN) + 38'(32768);

    always_comb begin
        sm_next       = c1s_reg[N];
        sm_next.theta = c1z_reg[N] ? '0 : c1a_reg[N];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg  <= CW'(r_prod[37:16]);
            sm_reg <= sm_next;
        end
    end

    // Second CORDIC: elevation.
    logic signed [CW-1:0] c2x_reg [0:N];
    logic signed [CW-1:0] c2y_reg [0:N];
    logic signed [AW-1:0] c2a_reg [0:N];
    logic                 c2z_reg [0:N];
    side_t                c2s_reg [0:N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2x_reg[0] <= r_reg;
            c2y_reg[0] <= sm_reg.pz;
            c2a_reg[0] <= '0;
            c2z_reg[0] <= (r_reg == '0) && (sm_reg.pz == '0);
            c2s_reg[0] <= sm_reg;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_c2
        always_ff @(posedge aclk) begin
            if (adv) begin
                c2z_reg[k+1] <= c2z_reg[k];
                c2s_reg[k+1] <= c2s_reg[k];
                if (c2y_reg[k] >= 0) begin
                    c2x_reg[k+1] <= c2x_reg[k] + (c2y_reg[k] >>> k);
                    c2y_reg[k+1] <= c2y_reg[k] - (c2x_reg[k] >>> k);
                    c2a_reg[k+1] <= c2a_reg[k] + AW'(ATAN_TAB[k]);
                end else begin
                    c2x_reg[k+1] <= c2x_reg[k] - (c2y_reg[k] >>> k);
                    c2y_reg[k+1] <= c2y_reg[k] + (c2x_reg[k] >>> k);
                    c2a_reg[k+1] <= c2a_reg[k] - AW'(ATAN_TAB[k]);
                end
            end
        end
    end

    // Angle sums, clamped.
    logic signed [AW+1:0] t_sum, s_sum, phi;
    logic [TW-1:0]        t_reg, s_reg;
    side_t                sa_reg;

    assign phi   = c2z_reg[N] ? '0 : (AW+2)'(c2a_reg[N]);
    assign t_sum = (AW+2)'(signed'(c2s_reg[N].theta)) + (AW+2)'(FX_PI);
    assign s_sum = (AW+2)'(FX_HALF_PI) - phi;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg <= c2s_reg[N];
            if (t_sum < 0)
                t_reg <= '0;
            else if (t_sum > (AW+2)'(2 * FX_PI))
                t_reg <= TW'(2 * FX_PI);
            else
                t_reg <= TW'(t_sum);
            if (s_sum < 0)
                s_reg <= '0;
            else if (s_sum > (AW+2)'(FX_PI))
                s_reg <= TW'(FX_PI);
            else
                s_reg <= TW'(s_sum);
        end
    end

    // Scale to source coordinates in two multiplier stages.
    logic [PW-1:0] pu_reg, pv_reg;
    logic [UW-1:0] uf_reg, vf_reg;
    logic [PW+22:0] uprod, vprod;
    side_t         sp1_reg, sp2_reg;

    assign uprod = (PW+23)'(pu_reg) * (PW+23)'(FX_INV_PI_Q24) + (PW+23)'(1 << 23);
    assign vprod = (PW+23)'(pv_reg) * (PW+23)'(FX_INV_PI_Q24) + (PW+23)'(1 << 23);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pu_reg  <= PW'({fs, 1'b0}) * PW'(t_reg);
            pv_reg  <= PW'({fs, 1'b0}) * PW'(s_reg);
            sp1_reg <= sa_reg;
            uf_reg  <= uprod[PW+22:24];
            vf_reg  <= vprod[PW+22:24];
            sp2_reg <= sp1_reg;
        end
    end

    // Split into neighbors and weights.
    logic [UW-1:0] ufl, vfl, ul_w, vl_w, fu_w, fv_w;
    logic [WW-1:0] ul, vl, uh, vh;
    logic [FW-1:0] fu, fv;

    assign ufl  = uf_reg >> 16;
    assign vfl  = vf_reg >> 16;
    assign ul   = (ufl > UW'(w_m1)) ? w_m1 : WW'(ufl);
    assign vl   = (vfl > UW'(h_m1)) ? h_m1 : WW'(vfl);
    assign uh   = ((WW+1)'(ul) + 1'b1 > (WW+1)'(w_m1)) ? w_m1 : ul + 1'b1;
    assign vh   = ((WW+1)'(vl) + 1'b1 > (WW+1)'(h_m1)) ? h_m1 : vl + 1'b1;
    assign ul_w = UW'(ul) << 16;
    assign vl_w = UW'(vl) << 16;
    assign fu_w = (uf_reg - ul_w) >> (16 - FRAC_BITS);
    assign fv_w = (vf_reg - vl_w) >> (16 - FRAC_BITS);
    assign fu   = (fu_w > UW'(1 << FRAC_BITS)) ? FW'(1 << FRAC_BITS) : FW'(fu_w);
    assign fv   = (fv_w > UW'(1 << FRAC_BITS)) ? FW'(1 << FRAC_BITS) : FW'(fv_w);

    logic [12:0]   dst_x_reg, dst_y_reg, u_lo_reg, u_hi_reg, v_lo_reg, v_hi_reg;
    logic [FW-1:0] frac_u_reg, frac_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dst_x_reg  <= sp2_reg.dst_x;
            dst_y_reg  <= sp2_reg.dst_y;
            u_lo_reg   <= 13'(ul);
            u_hi_reg   <= 13'(uh);
            v_lo_reg   <= 13'(vl);
            v_hi_reg   <= 13'(vh);
            frac_u_reg <= fu;
            frac_v_reg <= fv;
        end
    end

    assign m_tdata = OW'({frac_v_reg, frac_u_reg, v_hi_reg, v_lo_reg, u_hi_reg, u_lo_reg,
                          dst_y_reg, dst_x_reg});

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (frac_u_reg <= FW'(1 << FRAC_BITS)) && (frac_v_reg <= FW'(1 << FRAC_BITS)))
        else $error("weight above one");

    a_neighbor_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (u_lo_reg <= u_hi_reg) && (v_lo_reg <= v_hi_reg))
        else $error("neighbor below floor");

endmodule

### tb/sv/e2cx_checker.sv
// ----------------------------------------------------------------------------
// e2cx_checker
// Watches the pixel and sample channels and the register port of the cross
// sampler, computes the expected source sample for every accepted pixel and
// compares each returned word with the oldest pending prediction.
// ----------------------------------------------------------------------------
module e2cx_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import e2cx_pkg::*;

    typedef struct packed {
        logic [8:0]  frac_v;
        logic [8:0]  frac_u;
        logic [12:0] v_hi;
        logic [12:0] v_lo;
        logic [12:0] u_hi;
        logic [12:0] u_lo;
        logic [12:0] dst_y;
        logic [12:0] dst_x;
    } sample_t;

    sample_t     sample_fifo[$];
    logic [13:0] width_reg;
    logic [13:0] height_reg;

    // Vectoring CORDIC: returns the angle, writes the gained magnitude.
    function automatic longint vector_angle(longint y, longint x, output longint mag);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            ang = (y >= 0) ? FX_PI : -FX_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                ang += ATAN_TAB[i];
            end else begin
                x -= dx;
                y += dy;
                ang -= ATAN_TAB[i];
            end
        end
        mag = x;
        return ang;
    endfunction

    function automatic void split_pos(longint f16, longint lim, output logic [12:0] lo,
                                      output logic [12:0] hi, output logic [8:0] fr);
        longint l;
        longint h;
        longint f;
        l = f16 >> 16;
        if (l > lim) l = lim;
        h = (l + 1 > lim) ? lim : l + 1;
        f = (f16 - (l << 16)) >> 8;
        if (f > 256) f = 256;
        lo = l[12:0];
        hi = h[12:0];
        fr = f[8:0];
    endfunction

    function automatic sample_t map_pixel(logic [2:0] face, logic [10:0] col,
                                          logic [10:0] row);
        sample_t res;
        longint w, h, fs, a, b, px, py, pz, mag, r, theta, phi, t, s, uf, vf, offx, offy;
        w = (width_reg > 8192) ? 8192 : width_reg;
        h = (height_reg > 8192) ? 8192 : height_reg;
        fs = w >> 2;
        a = 0;
        b = 0;
        px = 0;
        py = 0;
        pz = 0;
        offx = 0;
        offy = 0;
        if (fs != 0) begin
            a = (longint'(col) << 17) / fs;
            b = (longint'(row) << 17) / fs;
            if (a > 131072) a = 131072;
            if (b > 131072) b = 131072;
        end
        case (face)
            3'd0: begin px = -FX_ONE; py = a - FX_ONE; pz = b - FX_ONE;
                offx = fs; offy = 3 * fs; end
            3'd1: begin px = a - FX_ONE; py = -FX_ONE; pz = FX_ONE - b;
                offx = 0; offy = fs; end
            3'd2: begin px = FX_ONE; py = a - FX_ONE; pz = FX_ONE - b;
                offx = fs; offy = fs; end
            3'd3: begin px = FX_ONE - a; py = FX_ONE; pz = FX_ONE - b;
                offx = 2 * fs; offy = fs; end
            3'd4: begin px = b - FX_ONE; py = a - FX_ONE; pz = FX_ONE;
                offx = fs; offy = 0; end
            3'd5: begin px = FX_ONE - b; py = a - FX_ONE; pz = -FX_ONE;
                offx = fs; offy = 2 * fs; end
            default: ;
        endcase
        theta = vector_angle(py, px, mag);
        r = (mag * FX_INV_GAIN + 32768) >> 16;
        phi = vector_angle(pz, r, mag);
        t = theta + FX_PI;
        if (t < 0) t = 0;
        if (t > 2 * FX_PI) t = 2 * FX_PI;
        s = FX_HALF_PI - phi;
        if (s < 0) s = 0;
        if (s > FX_PI) s = FX_PI;
        uf = (2 * fs * t * FX_INV_PI_Q24 + (longint'(1) << 23)) >> 24;
        vf = (2 * fs * s * FX_INV_PI_Q24 + (longint'(1) << 23)) >> 24;
        split_pos(uf, (w != 0) ? w - 1 : 0, res.u_lo, res.u_hi, res.frac_u);
        split_pos(vf, (h != 0) ? h - 1 : 0, res.v_lo, res.v_hi, res.frac_v);
        res.dst_x = 13'(col + offx);
        res.dst_y = 13'(row + offy);
        return res;
    endfunction

    assign pending = sample_fifo.size();

    always @(posedge aclk) begin
        sample_t want;
        sample_t got;
        if (!aresetn) begin
            width_reg <= 14'd1024;
            height_reg <= 14'd512;
            errors <= 0;
            sample_fifo.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (sample_fifo.size() == 0) begin
                    if (errors < 10)
                        $display("checker: unexpected word %h", m_tdata);
                    errors <= errors + 1;
                end else begin
                    want = sample_fifo.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("checker: mismatch expected %p got %p", want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                sample_fifo.push_back(map_pixel(s_tdata[2:0], s_tdata[13:3], s_tdata[24:14]));
            if (psel && penable && pwrite && pready) begin
                if (reg_idx_t'(paddr[2]) == REG_SRC_WIDTH)
                    width_reg <= pwdata[13:0];
                else
                    height_reg <= pwdata[13:0];
            end
        end
    end
endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case cube pixels through the cross sampler under
// several source sizes, with random stalls on both sides, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import e2cx_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          face_size;

    equirect_to_cube_cross_sampler_core DUT (.*);

    e2cx_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // The sample side stalls at random, with a periodic long hold.
    initial begin
        int cyc;
        int hold;
        cyc = 0;
        hold = 0;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 4000 == 1500) hold = 300;
            if (hold > 0) begin
                hold--;
                m_tready = 0;
            end else if (cyc % 4000 > 3000) begin
                m_tready = 1;
            end else begin
                m_tready = (gap_len() == 0);
            end
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic send_pixel(logic [2:0] face, logic [10:0] col, logic [10:0] row,
                              bit burst);
        int g;
        s_tdata = {7'd0, row, col, face};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        g = burst ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid = 0;
            s_tdata = $urandom;
            repeat (g) @(negedge aclk);
        end
    endtask

    function automatic logic [10:0] pick_coord();
        if (face_size > 0 && $urandom_range(0, 9) < 8)
            return 11'($urandom_range(0, (face_size > 2048 ? 2048 : face_size) - 1));
        return 11'($urandom);
    endfunction

    task automatic drain();
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int widths[11] = '{1024, 8192, 16383, 0, 3, 4, 7, 64, 2048, 1024, 100};
        int heights[11] = '{512, 4096, 16383, 0, 1, 1, 2, 32, 1024, 8192, 37};
        int fs;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        face_size = 256;
        repeat (3) @(negedge aclk);
        aresetn = 1;

        // Corners, centers and out-of-range points under the reset sizes.
        fs = 256;
        for (int f = 0; f < 8; f++) begin
            send_pixel(3'(f), 11'd0, 11'd0, 0);
            send_pixel(3'(f), 11'(fs - 1), 11'(fs - 1), 0);
        end
        for (int f = 0; f < 6; f++)
            send_pixel(3'(f), 11'(fs / 2), 11'(fs / 2), 0);
        send_pixel(3'd2, 11'd2047, 11'd2047, 0);
        send_pixel(3'd0, 11'd0, 11'd2047, 0);
        send_pixel(3'd7, 11'd2047, 11'd0, 0);

        for (int p = 0; p < 11; p++) begin
            drain();
            reg_write(REG_SRC_WIDTH, 32'(widths[p]) | ($urandom & 32'hFFFF_C000));
            reg_write(REG_SRC_HEIGHT, 32'(heights[p]));
            face_size = (widths[p] > 8192 ? 8192 : widths[p]) / 4;
            for (int i = 0; i < 105; i++)
                send_pixel(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                           : 3'($urandom_range(0, 5)), pick_coord(), pick_coord(),
                           (i % 50) > 35);
        end

        drain();
        repeat (80) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

### filelist.f
sv/e2cx_pkg.sv
sv/equirect_to_cube_cross_sampler_core.sv
tb/sv/e2cx_checker.sv
tb/sv/testbench.sv
